### rtl/linear_interp_upsampler_top_defines.svh
// Assertion macros for the upsampler.
`ifndef LINEAR_INTERP_UPSAMPLER_TOP_DEFINES_SVH
`define LINEAR_INTERP_UPSAMPLER_TOP_DEFINES_SVH

// same-cycle implication
`define LIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lip_pkg.sv
package lip_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int MAX_FACTOR   = 64;
    localparam int FACTOR_W     = 7;
    localparam int DIFF_W       = SAMPLE_WIDTH + 1;
    localparam int ALU_W        = FACTOR_W + 1;
    localparam int DIV_CNT_W    = $clog2(DIFF_W);
    localparam int OUT_SUM_W    = SAMPLE_WIDTH + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fix;
        logic emit;
        logic last;
    } ctl_t;

    function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        if (f == '0) begin
            r = FACTOR_W'(1);
        end else if (f > FACTOR_W'(MAX_FACTOR)) begin
            r = FACTOR_W'(MAX_FACTOR);
        end else begin
            r = f;
        end
        return r;
    endfunction

endpackage

### rtl/linear_interp_upsampler_top.sv
// Flow: after the input transfer a bit-serial divide runs, then a fix-up step, then the run.
// A new input is taken only once the run has ended. During a run, one output per cycle while
// the output register is empty or the sink is ready. The divide/step compare unit is shared.
// Reset: synchronous active-low aresetn; factor returns to 1, previous sample to zero,
// sequencer to idle, output register empty.
module linear_interp_upsampler_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lip_pkg::FACTOR_W-1:0]     cfg_data,   // up_factor
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lip_pkg::SAMPLE_WIDTH-1:0] s_tdata,    // sample_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lip_pkg::SAMPLE_WIDTH-1:0] m_tdata,    // sample_out
    output logic                             m_tlast     // run_last
);
    import lip_pkg::*;

    ctl_t                     ctl;
    logic                     s_fire;
    logic                     out_free;
    logic [FACTOR_W-1:0]      f_eff;

    logic [FACTOR_W-1:0]      factor_reg;
    logic [SAMPLE_WIDTH-1:0]  prev_reg;
    logic [SAMPLE_WIDTH-1:0]  base_reg;
    logic [DIFF_W-1:0]        dvd_reg;
    logic [FACTOR_W-1:0]      rem_reg;
    logic                     neg_reg;
    logic [DIFF_W-1:0]        qd_reg;
    logic [FACTOR_W-1:0]      rd_reg;
    logic [DIFF_W-1:0]        q_acc_reg;
    logic [FACTOR_W-1:0]      r_acc_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]  out_data_reg;
    logic                     out_last_reg;

    logic [DIFF_W-1:0]        diff;
    logic [DIFF_W-1:0]        mag;
    logic [ALU_W-1:0]         alu_a, alu_b, alu_diff;
    logic                     alu_ge;
    logic [DIFF_W-1:0]        q_step;
    logic [OUT_SUM_W-1:0]     out_sum;

    assign cfg_ready = 1'b1;
    assign f_eff     = eff_factor(factor_reg);
    assign s_fire    = s_tvalid & s_tready;
    assign out_free  = ~out_valid_reg | m_tready;

    lip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_fire   (s_fire),
        .out_free (out_free),
        .factor   (f_eff),
        .s_ready  (s_tready),
        .ctl      (ctl)
    );

    lip_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    always_comb begin
        priority if (ctl.fix) begin
            alu_a = {1'b0, f_eff};
            alu_b = {1'b0, rem_reg};
        end else if (ctl.div_step) begin
            alu_a = {rem_reg, dvd_reg[DIFF_W-1]};
            alu_b = {1'b0, f_eff};
        end else begin
            alu_a = {1'b0, r_acc_reg} + {1'b0, rd_reg};
            alu_b = {1'b0, f_eff};
        end
    end

    assign diff    = {s_tdata[SAMPLE_WIDTH-1], s_tdata} - {prev_reg[SAMPLE_WIDTH-1], prev_reg};
    assign mag     = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    assign q_step  = q_acc_reg + qd_reg + DIFF_W'(alu_ge);
    assign out_sum = {{2{base_reg[SAMPLE_WIDTH-1]}}, base_reg}
                   + {q_step[DIFF_W-1], q_step};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_W'(1);
            prev_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                factor_reg <= cfg_data;
            end
            if (ctl.load) begin
                prev_reg <= s_tdata;
            end
        end
    end

    // divide, fix-up and stepping datapath
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            base_reg <= prev_reg;
            neg_reg  <= diff[DIFF_W-1];
            dvd_reg  <= mag;
            rem_reg  <= '0;
        end
        if (ctl.div_step) begin
            dvd_reg <= {dvd_reg[DIFF_W-2:0], alu_ge};
            rem_reg <= alu_ge ? alu_diff[FACTOR_W-1:0] : alu_a[FACTOR_W-1:0];
        end
        if (ctl.fix) begin
            q_acc_reg <= '0;
            r_acc_reg <= '0;
            if (neg_reg && rem_reg != '0) begin
                qd_reg <= ~dvd_reg;
                rd_reg <= alu_diff[FACTOR_W-1:0];
            end else if (neg_reg) begin
                qd_reg <= ~dvd_reg + DIFF_W'(1);
                rd_reg <= '0;
            end else begin
                qd_reg <= dvd_reg;
                rd_reg <= rem_reg;
            end
        end
        if (ctl.emit) begin
            q_acc_reg    <= q_step;
            r_acc_reg    <= alu_ge ? alu_diff[FACTOR_W-1:0] : alu_a[FACTOR_W-1:0];
            out_data_reg <= out_sum[SAMPLE_WIDTH-1:0];
            out_last_reg <= ctl.last;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`include "linear_interp_upsampler_top_defines.svh"

    `LIP_ASSERT_NEXT(a_busy_after_load, s_fire, !s_tready, "ready after accepted sample")
    `LIP_ASSERT_NEXT(a_last_is_input, ctl.emit && ctl.last, m_tdata == prev_reg && m_tlast,
        "last output of run differs from input sample")
    `LIP_ASSERT_NEXT(a_idle_after_run, ctl.emit && ctl.last, s_tready,
        "not ready after run end")
    `LIP_ASSERT_NOW(a_emit_no_overrun, ctl.emit, !m_tvalid || m_tready,
        "output register overwritten")

endmodule

### rtl/lip_alu.sv
// shared subtract-and-compare unit
module lip_alu (
    input  logic [lip_pkg::ALU_W-1:0] a,
    input  logic [lip_pkg::ALU_W-1:0] b,
    output logic [lip_pkg::ALU_W-1:0] diff,
    output logic                      ge
);
    import lip_pkg::*;

    logic [ALU_W:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[ALU_W-1:0];
    assign ge   = ~full[ALU_W];

endmodule

### rtl/lip_ctrl.sv
module lip_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_fire,
    input  logic                         out_free,
    input  logic [lip_pkg::FACTOR_W-1:0] factor,
    output logic                         s_ready,
    output lip_pkg::ctl_t                ctl
);
    import lip_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIFF_W - 1);

    state_t                state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FACTOR_W-1:0]   k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_DIV;
                    cnt_next   = DIV_LAST;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                state_next = ST_RUN;
                k_next     = FACTOR_W'(1);
            end
            ST_RUN: begin
                if (out_free) begin
                    k_next = k_reg + FACTOR_W'(1);
                    if (k_reg == factor) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        ctl          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                ctl.load = s_fire;
            end
            ST_DIV:  ctl.div_step = 1'b1;
            ST_FIX:  ctl.fix      = 1'b1;
            ST_RUN: begin
                ctl.emit = out_free;
                ctl.last = (k_reg == factor);
            end
            default: ctl = '0;
        endcase
    end

endmodule
